// ===== src/mspb_pkg.sv =====
// shared types and constants of the masked sprite pixel blitter
`timescale 1ns / 1ps

package mspb_pkg;

    localparam int MAX_SCREEN_SIDE = 4096;
    localparam int MAX_SPRITE_SIDE = 256;

    localparam int PIX_W    = 8;
    localparam int PLACE_W  = 16;
    localparam int LOCAL_W  = $clog2(MAX_SPRITE_SIDE);
    localparam int COORD_W  = PLACE_W + 1;
    localparam int SIDE_W   = 13;
    localparam int PITCH_W  = 14;
    localparam int ADDR_W   = 24;
    localparam int POS_W    = $clog2(MAX_SCREEN_SIDE);
    localparam int PROD_W   = POS_W + PITCH_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SCREEN_SIDE);
    localparam logic [PIX_W-1:0]  SHADOW_ADD = 8'h06;

    localparam logic [SIDE_W-1:0]  RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [SIDE_W-1:0]  RST_SCREEN_HEIGHT = 13'd240;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH    = 14'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_LINE_PITCH    = 2'd2
    } cfg_reg_e_t;

    typedef struct packed {
        logic [PLACE_W-1:0] place_x;
        logic [PLACE_W-1:0] place_y;
        logic [LOCAL_W-1:0] hotspot_x;
        logic [LOCAL_W-1:0] hotspot_y;
        logic [LOCAL_W-1:0] local_x;
        logic [LOCAL_W-1:0] local_y;
        logic [PIX_W-1:0]   sprite_pixel;
        logic [PIX_W-1:0]   sprite_mask;
        logic [PIX_W-1:0]   screen_pixel;
        logic [PIX_W-1:0]   backdrop_pixel;
        logic               shadow_mode;
    } pix_in_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  new_pixel;
    } pix_out_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  screen_width;
        logic [SIDE_W-1:0]  screen_height;
        logic [PITCH_W-1:0] line_pitch;
    } blit_cfg_t;

endpackage

// ===== src/mspb_compute.sv =====
// clipping, address and byte compositing for one sprite pixel
`timescale 1ns / 1ps

module mspb_compute
    import mspb_pkg::*;
(
    input  pix_in_t   pix_in,
    input  blit_cfg_t cfg,
    output pix_out_t  pix_out
);

    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic [SIDE_W-1:0]         w_clamp;
    logic [SIDE_W-1:0]         h_clamp;
    logic                      on_screen;
    logic [PIX_W-1:0]          nmask;
    logic [PIX_W-1:0]          shadow_byte;
    logic [PIX_W-1:0]          blend;
    logic [PROD_W-1:0]         row_base;
    logic [ADDR_W-1:0]         addr;

    // screen position = placement - hot-spot + local, 17 bits hold every case
    assign sx = $signed({pix_in.place_x[PLACE_W-1], pix_in.place_x})
              - $signed({{(COORD_W-LOCAL_W){1'b0}}, pix_in.hotspot_x})
              + $signed({{(COORD_W-LOCAL_W){1'b0}}, pix_in.local_x});
    assign sy = $signed({pix_in.place_y[PLACE_W-1], pix_in.place_y})
              - $signed({{(COORD_W-LOCAL_W){1'b0}}, pix_in.hotspot_y})
              + $signed({{(COORD_W-LOCAL_W){1'b0}}, pix_in.local_y});

    assign w_clamp = (cfg.screen_width  > SIDE_LIMIT) ? SIDE_LIMIT : cfg.screen_width;
    assign h_clamp = (cfg.screen_height > SIDE_LIMIT) ? SIDE_LIMIT : cfg.screen_height;

    // local coordinates are LOCAL_W bits wide, so they never reach the sprite limit
    assign on_screen = !sx[COORD_W-1]
                    && (sx[COORD_W-2:0] < {{(COORD_W-1-SIDE_W){1'b0}}, w_clamp})
                    && !sy[COORD_W-1]
                    && (sy[COORD_W-2:0] < {{(COORD_W-1-SIDE_W){1'b0}}, h_clamp});

    // shadow add stays inside the byte
    assign nmask       = ~pix_in.sprite_mask;
    assign shadow_byte = (pix_in.backdrop_pixel & nmask) + (nmask & SHADOW_ADD);
    assign blend       = (pix_in.screen_pixel & pix_in.sprite_mask)
                       | (pix_in.shadow_mode ? shadow_byte : pix_in.sprite_pixel);

    // inside the screen both coordinates fit in POS_W bits
    assign row_base = PROD_W'(sy[POS_W-1:0]) * PROD_W'(cfg.line_pitch);
    assign addr     = row_base[ADDR_W-1:0] + ADDR_W'(sx[POS_W-1:0]);

    always_comb begin
        pix_out.write_enable  = on_screen;
        pix_out.write_address = on_screen ? addr : '0;
        pix_out.new_pixel     = on_screen ? blend : pix_in.screen_pixel;
    end

endmodule

// ===== src/masked_sprite_pixel_blit.sv =====
// top level of the masked sprite pixel blitter
`timescale 1ns / 1ps

// masked sprite pixel blitter: one transaction on the s_ side carries one sprite
// pixel with its placement, hot-spot, mask, the current screen byte and the
// backdrop byte; one transaction on the m_ side returns the clipped write enable,
// the linear write address (row * line_pitch + column, modulo 2^24) and the
// composited byte. off-screen pixels come back with write_enable 0, address 0
// and the screen byte unchanged. the block takes one pixel every clock while
// m_ready keeps the output moving; a pixel passes the input register, the
// single compute stage and the output register, and the compute stage's longest
// path is the 12 x 14 bit row multiply plus the column add.
// an input register and an output register separate the two sides, so a pixel
// is still accepted while a finished one waits on m_ready, as long as the input register is empty. configuration
// registers (screen_width, screen_height, line_pitch) are written through the
// cfg port, which is always ready; indexes past the list are ignored.

module masked_sprite_pixel_blit
    import mspb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PITCH_W-1:0]   cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PLACE_W-1:0]   s_place_x,
    input  logic [PLACE_W-1:0]   s_place_y,
    input  logic [LOCAL_W-1:0]   s_hotspot_x,
    input  logic [LOCAL_W-1:0]   s_hotspot_y,
    input  logic [LOCAL_W-1:0]   s_local_x,
    input  logic [LOCAL_W-1:0]   s_local_y,
    input  logic [PIX_W-1:0]     s_sprite_pixel,
    input  logic [PIX_W-1:0]     s_sprite_mask,
    input  logic [PIX_W-1:0]     s_screen_pixel,
    input  logic [PIX_W-1:0]     s_backdrop_pixel,
    input  logic                 s_shadow_mode,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_write_enable,
    output logic [ADDR_W-1:0]    m_write_address,
    output logic [PIX_W-1:0]     m_new_pixel
);

    // configuration registers
    blit_cfg_t cfg_reg;
    blit_cfg_t cfg_next;

    // input stage
    logic      in_valid_reg;
    logic      in_valid_next;
    pix_in_t   in_data_reg;
    pix_in_t   in_data_next;

    // output stage
    logic      out_valid_reg;
    logic      out_valid_next;
    pix_out_t  out_data_reg;
    pix_out_t  out_data_next;

    pix_out_t  comp_result;
    logic      s_accept;
    logic      out_load;
    logic      in_advance;

    // config writes never stall
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[SIDE_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[SIDE_W-1:0];
                REG_LINE_PITCH:    cfg_next.line_pitch    = cfg_data;
                default:           cfg_next = cfg_reg;  // unknown index, ignore
            endcase
        end
    end

    // output register frees up when empty or when its transaction completes
    assign out_load   = !out_valid_reg || m_ready;
    // input stage moves forward whenever the output can take it
    assign in_advance = out_load;
    assign s_ready    = !in_valid_reg || in_advance;
    assign s_accept   = s_valid && s_ready;

    always_comb begin
        in_data_next.place_x        = s_place_x;
        in_data_next.place_y        = s_place_y;
        in_data_next.hotspot_x      = s_hotspot_x;
        in_data_next.hotspot_y      = s_hotspot_y;
        in_data_next.local_x        = s_local_x;
        in_data_next.local_y        = s_local_y;
        in_data_next.sprite_pixel   = s_sprite_pixel;
        in_data_next.sprite_mask    = s_sprite_mask;
        in_data_next.screen_pixel   = s_screen_pixel;
        in_data_next.backdrop_pixel = s_backdrop_pixel;
        in_data_next.shadow_mode    = s_shadow_mode;
    end

    // per-pixel math between the two registers
    mspb_compute u_compute (
        .pix_in  (in_data_reg),
        .cfg     (cfg_reg),
        .pix_out (comp_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
        out_data_next = comp_result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.line_pitch    <= RST_LINE_PITCH;
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= in_data_next;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_enable  = out_data_reg.write_enable;
    assign m_write_address = out_data_reg.write_address;
    assign m_new_pixel     = out_data_reg.new_pixel;

    // off-screen results carry a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_enable) |-> (m_write_address == '0))
        else $error("off-screen transaction with nonzero address");

    // a pixel in the input stage reaches the output register when it advances
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_advance) |=> m_valid)
        else $error("pixel lost between input and output stage");

    // both stages full and output stalled: no new transaction is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline is full");

    // a stalled result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_data_reg)))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/masked_sprite_pixel_blit_test.sv =====
// self-checking testbench of the masked sprite pixel blitter
`timescale 1ns / 1ps

module masked_sprite_pixel_blit_test;
    import mspb_pkg::*;

    // register index past the end of the list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // idle clocks added after the last result comes back, to keep some margin
    localparam int PIPE_SETTLE  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 300;
    localparam int LONG_HOLD    = 400;
    localparam int PRINT_CAP    = 100;

    // expected pixel store plus bit-true model of the compositor
    class blit_scoreboard;
        blit_cfg_t cfg;
        pix_out_t  pending_px[$];
        int        errors;
        int        checked;

        function void reset_cfg();
            cfg.screen_width  = RST_SCREEN_WIDTH;
            cfg.screen_height = RST_SCREEN_HEIGHT;
            cfg.line_pitch    = RST_LINE_PITCH;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PITCH_W-1:0] data);
            case (idx)
                REG_SCREEN_WIDTH:  cfg.screen_width  = data[SIDE_W-1:0];
                REG_SCREEN_HEIGHT: cfg.screen_height = data[SIDE_W-1:0];
                REG_LINE_PITCH:    cfg.line_pitch    = data;
                default: ;
            endcase
        endfunction

        // sizes above the largest screen saturate
        function int width_px();
            return (int'(cfg.screen_width) > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE
                                                              : int'(cfg.screen_width);
        endfunction

        function int height_px();
            return (int'(cfg.screen_height) > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE
                                                               : int'(cfg.screen_height);
        endfunction

        function pix_out_t composite(pix_in_t p);
            int               sx;
            int               sy;
            logic [PIX_W-1:0] nmask;
            logic [PIX_W-1:0] shade;
            logic [47:0]      addr;
            pix_out_t         r;
            sx = int'($signed(p.place_x)) - int'(p.hotspot_x) + int'(p.local_x);
            sy = int'($signed(p.place_y)) - int'(p.hotspot_y) + int'(p.local_y);
            if (sx < 0 || sx >= width_px() || sy < 0 || sy >= height_px()) begin
                r.write_enable  = 1'b0;
                r.write_address = '0;
                r.new_pixel     = p.screen_pixel;
                return r;
            end
            nmask = ~p.sprite_mask;
            // shadow sum stays inside the byte, carry out is dropped
            shade = (p.backdrop_pixel & nmask) + (nmask & SHADOW_ADD);
            if (p.shadow_mode)
                r.new_pixel = (p.screen_pixel & p.sprite_mask) | shade;
            else
                r.new_pixel = (p.screen_pixel & p.sprite_mask) | p.sprite_pixel;
            addr = 48'(sy) * 48'(cfg.line_pitch) + 48'(sx);
            r.write_enable  = 1'b1;
            r.write_address = addr[ADDR_W-1:0];
            return r;
        endfunction

        function void note_pixel(pix_in_t p);
            pending_px.push_back(composite(p));
        endfunction

        function int pending();
            return pending_px.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch at result %0d: %s", checked, what);
        endtask

        task check_pixel(pix_out_t got);
            pix_out_t want;
            if (pending_px.size() == 0) begin
                report($sformatf("unexpected result we=%0b addr=%h pix=%h",
                                 got.write_enable, got.write_address, got.new_pixel));
                return;
            end
            want = pending_px.pop_front();
            if (got.write_enable !== want.write_enable)
                report($sformatf("write_enable %0b, expected %0b",
                                 got.write_enable, want.write_enable));
            if (got.write_address !== want.write_address)
                report($sformatf("write_address %h, expected %h",
                                 got.write_address, want.write_address));
            if (got.new_pixel !== want.new_pixel)
                report($sformatf("new_pixel %h, expected %h",
                                 got.new_pixel, want.new_pixel));
            checked++;
        endtask
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PITCH_W-1:0]   cfg_data  = '0;

    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [PLACE_W-1:0] s_place_x        = '0;
    logic [PLACE_W-1:0] s_place_y        = '0;
    logic [LOCAL_W-1:0] s_hotspot_x      = '0;
    logic [LOCAL_W-1:0] s_hotspot_y      = '0;
    logic [LOCAL_W-1:0] s_local_x        = '0;
    logic [LOCAL_W-1:0] s_local_y        = '0;
    logic [PIX_W-1:0]   s_sprite_pixel   = '0;
    logic [PIX_W-1:0]   s_sprite_mask    = '0;
    logic [PIX_W-1:0]   s_screen_pixel   = '0;
    logic [PIX_W-1:0]   s_backdrop_pixel = '0;
    logic               s_shadow_mode    = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_write_enable;
    logic [ADDR_W-1:0] m_write_address;
    logic [PIX_W-1:0]  m_new_pixel;

    blit_scoreboard sb = new();

    // idle percentages per phase, and the long receiver hold-off counter
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    masked_sprite_pixel_blit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_place_x        (s_place_x),
        .s_place_y        (s_place_y),
        .s_hotspot_x      (s_hotspot_x),
        .s_hotspot_y      (s_hotspot_y),
        .s_local_x        (s_local_x),
        .s_local_y        (s_local_y),
        .s_sprite_pixel   (s_sprite_pixel),
        .s_sprite_mask    (s_sprite_mask),
        .s_screen_pixel   (s_screen_pixel),
        .s_backdrop_pixel (s_backdrop_pixel),
        .s_shadow_mode    (s_shadow_mode),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_enable   (m_write_enable),
        .m_write_address  (m_write_address),
        .m_new_pixel      (m_new_pixel)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("masked_sprite_pixel_blit_test: FAIL");
        $finish;
    end

    // result side: check every transaction, then pick ready for the next edge
    initial begin
        pix_out_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.write_enable  = m_write_enable;
                got.write_address = m_write_address;
                got.new_pixel     = m_new_pixel;
                sb.check_pixel(got);
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                // long hold-off so the block fills up and drops s_ready
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic pix_in_t make_pixel(
        logic [PLACE_W-1:0] px, logic [PLACE_W-1:0] py,
        logic [LOCAL_W-1:0] hx, logic [LOCAL_W-1:0] hy,
        logic [LOCAL_W-1:0] lx, logic [LOCAL_W-1:0] ly,
        logic [PIX_W-1:0] spr, logic [PIX_W-1:0] msk,
        logic [PIX_W-1:0] scr, logic [PIX_W-1:0] bkg, logic shadow);
        pix_in_t p;
        p.place_x        = px;
        p.place_y        = py;
        p.hotspot_x      = hx;
        p.hotspot_y      = hy;
        p.local_x        = lx;
        p.local_y        = ly;
        p.sprite_pixel   = spr;
        p.sprite_mask    = msk;
        p.screen_pixel   = scr;
        p.backdrop_pixel = bkg;
        p.shadow_mode    = shadow;
        return p;
    endfunction

    // screen coordinate biased to the edges of the visible area
    function automatic int pick_coord(int side);
        case ($urandom_range(9))
            0: return -1 - int'($urandom_range(7));
            1: return side + int'($urandom_range(7));
            2: return 0;
            3: return side - 1;
            default: return (side > 1) ? int'($urandom_range(side - 1)) : 0;
        endcase
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        int      tx;
        int      ty;
        p.place_x        = PLACE_W'($urandom);
        p.place_y        = PLACE_W'($urandom);
        p.hotspot_x      = LOCAL_W'($urandom);
        p.hotspot_y      = LOCAL_W'($urandom);
        p.local_x        = LOCAL_W'($urandom);
        p.local_y        = LOCAL_W'($urandom);
        p.sprite_pixel   = PIX_W'($urandom);
        p.screen_pixel   = PIX_W'($urandom);
        p.backdrop_pixel = PIX_W'($urandom);
        p.shadow_mode    = 1'($urandom);
        case ($urandom_range(3))
            0: p.sprite_mask = 8'h00;
            1: p.sprite_mask = 8'hFF;
            default: p.sprite_mask = PIX_W'($urandom);
        endcase
        // most pixels aim at the screen, the rest keep a wild placement
        if ($urandom_range(99) < 75) begin
            tx = pick_coord(sb.width_px());
            ty = pick_coord(sb.height_px());
            p.place_x = PLACE_W'(tx + int'(p.hotspot_x) - int'(p.local_x));
            p.place_y = PLACE_W'(ty + int'(p.hotspot_y) - int'(p.local_y));
        end
        return p;
    endfunction

    // offer one pixel, idling first at the phase rate; valid is left high
    task automatic send_pixel(pix_in_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_place_x        <= p.place_x;
        s_place_y        <= p.place_y;
        s_hotspot_x      <= p.hotspot_x;
        s_hotspot_y      <= p.hotspot_y;
        s_local_x        <= p.local_x;
        s_local_y        <= p.local_y;
        s_sprite_pixel   <= p.sprite_pixel;
        s_sprite_mask    <= p.sprite_mask;
        s_screen_pixel   <= p.screen_pixel;
        s_backdrop_pixel <= p.backdrop_pixel;
        s_shadow_mode    <= p.shadow_mode;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(p);
    endtask

    // sender goes quiet until every pending pixel has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // block fully idle before a register write
    task automatic drain();
        wait_results();
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PITCH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int send_pct, int recv_pct, int pause_at, int hold_at);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == pause_at)
                wait_results();
            if (i == hold_at)
                hold_left = LONG_HOLD;
            send_pixel(random_pixel());
        end
        drain();
    endtask

    initial begin
        sb.reset_cfg();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pixels on the reset screen of 320 x 240, pitch 320
        send_pixel(make_pixel(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'hAB, 8'h00, 8'h55, 8'h11, 1'b0));   // top-left corner
        send_pixel(make_pixel(16'd319, 16'd239, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h3C, 8'h00, 8'h55, 8'h11, 1'b0));   // bottom-right corner
        send_pixel(make_pixel(16'd320, 16'd10, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h3C, 8'h00, 8'h55, 8'h11, 1'b0));   // one past right edge
        send_pixel(make_pixel(16'd10, 16'd240, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h3C, 8'h00, 8'h55, 8'h11, 1'b0));   // one past bottom
        send_pixel(make_pixel(16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h3C, 8'h00, 8'h55, 8'h11, 1'b0));   // left of screen
        send_pixel(make_pixel(16'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h3C, 8'h00, 8'h55, 8'h11, 1'b0));   // above screen
        send_pixel(make_pixel(16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 8'h00, 8'h5A, 8'h11, 1'b0));   // largest placement
        send_pixel(make_pixel(16'h8000, 16'h8000, 8'd0, 8'd0, 8'hFF, 8'hFF,
                              8'h00, 8'h00, 8'hA5, 8'h11, 1'b1));   // most negative placement
        send_pixel(make_pixel(16'd255, 16'd255, 8'hFF, 8'hFF, 8'd0, 8'd0,
                              8'h77, 8'h00, 8'h00, 8'h00, 1'b0));   // hot-spot cancels placement
        send_pixel(make_pixel(16'd0, 16'd0, 8'd0, 8'd0, 8'hFF, 8'd200,
                              8'h77, 8'h00, 8'h00, 8'h00, 1'b0));   // far sprite column
        send_pixel(make_pixel(16'd40, 16'd30, 8'd8, 8'd8, 8'd3, 8'd4,
                              8'h0F, 8'hFF, 8'hF0, 8'h00, 1'b0));   // transparent, normal draw
        send_pixel(make_pixel(16'd41, 16'd30, 8'd8, 8'd8, 8'd3, 8'd4,
                              8'h00, 8'h00, 8'h99, 8'hFE, 1'b1));   // shadow add drops carry
        send_pixel(make_pixel(16'd42, 16'd30, 8'd8, 8'd8, 8'd3, 8'd4,
                              8'h00, 8'hFF, 8'h99, 8'hFE, 1'b1));   // transparent shadow
        send_pixel(make_pixel(16'd43, 16'd30, 8'd8, 8'd8, 8'd3, 8'd4,
                              8'h00, 8'hF0, 8'hAA, 8'hFF, 1'b1));   // half mask shadow
        send_pixel(make_pixel(16'd500, 16'd30, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h00, 8'h00, 8'hC3, 8'hFF, 1'b1));   // shadow off screen
        send_pixel(make_pixel(16'd100, 16'd100, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));   // every byte all ones
        drain();

        // zero sized screen: nothing lands
        write_cfg(REG_SCREEN_WIDTH, 14'd0);
        write_cfg(REG_SCREEN_HEIGHT, 14'd0);
        send_pixel(make_pixel(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h12, 8'h00, 8'h34, 8'h56, 1'b0));
        send_pixel(make_pixel(16'd5, 16'd5, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h12, 8'h00, 8'h34, 8'h56, 1'b1));
        drain();

        // oversized screen saturates, widest pitch makes the address wrap;
        // all-ones data also checks that bit 13 is dropped for the sides
        write_cfg(REG_SCREEN_WIDTH, 14'h3FFF);
        write_cfg(REG_SCREEN_HEIGHT, 14'h3FFF);
        write_cfg(REG_LINE_PITCH, 14'h3FFF);
        send_pixel(make_pixel(16'd4095, 16'd4095, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h81, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(16'd4096, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h81, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(16'd0, 16'd4096, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h81, 8'h00, 8'h00, 8'h00, 1'b0));
        drain();

        // zero pitch leaves just the column; the unused index must not land
        write_cfg(REG_LINE_PITCH, 14'd0);
        write_cfg(REG_UNUSED, 14'd5);
        send_pixel(make_pixel(16'd1234, 16'd2000, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h42, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(16'd4000, 16'd10, 8'd0, 8'd0, 8'd0, 8'd0,
                              8'h42, 8'h00, 8'h00, 8'h00, 1'b0));
        drain();

        // random phases, each under its own screen setting and idling mix
        write_cfg(REG_SCREEN_WIDTH, 14'd320);
        write_cfg(REG_SCREEN_HEIGHT, 14'd240);
        write_cfg(REG_LINE_PITCH, 14'd320);
        random_phase(0, 0, -1, -1);

        write_cfg(REG_SCREEN_WIDTH, 14'd4096);
        write_cfg(REG_SCREEN_HEIGHT, 14'd4096);
        write_cfg(REG_LINE_PITCH, 14'd16383);
        random_phase(56, 0, PHASE_ITEMS / 2, -1);

        write_cfg(REG_SCREEN_WIDTH, 14'd1);
        write_cfg(REG_SCREEN_HEIGHT, 14'd8191);
        write_cfg(REG_LINE_PITCH, 14'd1);
        random_phase(0, 56, -1, -1);

        write_cfg(REG_SCREEN_WIDTH, 14'($urandom_range(600, 1)));
        write_cfg(REG_SCREEN_HEIGHT, 14'($urandom_range(600, 1)));
        write_cfg(REG_LINE_PITCH, 14'($urandom_range(16383, 1)));
        random_phase(37, 37, -1, PHASE_ITEMS / 3);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("masked_sprite_pixel_blit_test: PASS");
        else
            $display("masked_sprite_pixel_blit_test: FAIL");
        $finish;
    end

endmodule
